// ===== hdl/aac_pkg.sv =====
// Shared types and constants for the airtime admission control block.
package aac_pkg;

  localparam int unsigned THR_W  = 16;
  localparam int unsigned AIR_W  = 20;
  localparam int unsigned CLS_W  = 2;
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned RATE_W = 30;
  localparam int unsigned IDX_W  = 3;

  // airtime = rate * (8*size + 10000) * 176 / (1953125 * size)
  localparam int unsigned TERM_W = 20;  // 8*size + 10000
  localparam int unsigned PROD_W = RATE_W + TERM_W;
  localparam int unsigned NUM_W  = 58;
  localparam int unsigned DEN_W  = 37;

  localparam logic [TERM_W-1:0] TERM_OFFSET = TERM_W'(10000);
  localparam logic [7:0]        AIR_GAIN    = 8'd176;
  localparam logic [20:0]       DEN_SCALE   = 21'd1953125;
  localparam logic [AIR_W-1:0]  AIR_MAX     = {AIR_W{1'b1}};

  // utilization bands, Q0.16: above 0.95 lowers, (0.70, 0.90] raises
  localparam logic [THR_W-1:0] UTIL_LOWER_MIN = 16'd62260;
  localparam logic [THR_W-1:0] UTIL_RAISE_MIN = 16'd45876;
  localparam logic [THR_W-1:0] UTIL_RAISE_MAX = 16'd58982;

  // register indexes
  localparam logic [IDX_W-1:0] REG_VOICE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_VIDEO    = 3'd1;
  localparam logic [IDX_W-1:0] REG_B_START  = 3'd2;
  localparam logic [IDX_W-1:0] REG_DEFAULT  = 3'd3;
  localparam logic [IDX_W-1:0] REG_B_FLOOR  = 3'd4;
  localparam logic [IDX_W-1:0] REG_B_CEIL   = 3'd5;
  localparam logic [IDX_W-1:0] REG_B_STEP   = 3'd6;

  // register reset values
  localparam logic [THR_W-1:0] RST_VOICE   = 16'd58982;
  localparam logic [THR_W-1:0] RST_VIDEO   = 16'd52429;
  localparam logic [THR_W-1:0] RST_B_START = 16'd62259;
  localparam logic [THR_W-1:0] RST_DEFAULT = 16'd52429;
  localparam logic [THR_W-1:0] RST_B_FLOOR = 16'd52429;
  localparam logic [THR_W-1:0] RST_B_CEIL  = 16'd64225;
  localparam logic [THR_W-1:0] RST_B_STEP  = 16'd655;

  // traffic classes
  localparam logic [CLS_W-1:0] CLS_VOICE  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_VIDEO  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_BURSTY = 2'd2;
  localparam logic [CLS_W-1:0] CLS_OTHER  = 2'd3;

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic [AIR_W-1:0] air;
  } aac_item_t;

  typedef struct packed {
    logic [THR_W-1:0] voice;
    logic [THR_W-1:0] video;
    logic [THR_W-1:0] dflt;
    logic [THR_W-1:0] b_floor;
    logic [THR_W-1:0] b_ceil;
    logic [THR_W-1:0] b_step;
  } aac_cfg_t;

  typedef struct packed {
    logic             load;
    logic [THR_W-1:0] value;
  } aac_bload_t;

endpackage

// ===== hdl/airtime_admission_control.sv =====
// Top level of the airtime admission control block: register file, front end, queue, back end.
//
// Each request (class, packet size, rate) gets one result word. The front end takes a
// request, forms the airtime numerator and denominator in the states F_MUL1 and F_MUL2,
// runs a 20-step restoring divider and takes no new request until it has queued the
// result. The back end adapts the bursty threshold and then decides, overlapped with the
// next request through a short queue, and its result register lets the front carry on
// while a result waits to be taken. Configuration writes are always taken; writing
// bursty_start also reloads the adaptive threshold.
module airtime_admission_control
  import aac_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CLS_W-1:0]  traffic_class_i,
  input  logic [SIZE_W-1:0] packet_size_i,
  input  logic [RATE_W-1:0] flow_rate_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              admitted_o,
  output logic [AIR_W-1:0]  required_airtime_o,
  output logic [THR_W-1:0]  threshold_used_o,
  output logic [THR_W-1:0]  utilization_now_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [IDX_W-1:0]  cfg_index_i,
  input  logic [THR_W-1:0]  cfg_data_i
);

  aac_cfg_t   cfg_q;
  aac_bload_t bload;
  logic       cfg_we;

  logic      push, full, pop, empty;
  aac_item_t push_item, pop_item;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  assign bload.load  = cfg_we && (cfg_index_i == REG_B_START);
  assign bload.value = cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.voice   <= RST_VOICE;
      cfg_q.video   <= RST_VIDEO;
      cfg_q.dflt    <= RST_DEFAULT;
      cfg_q.b_floor <= RST_B_FLOOR;
      cfg_q.b_ceil  <= RST_B_CEIL;
      cfg_q.b_step  <= RST_B_STEP;
    end else if (cfg_we) begin
      // bursty_start lives only in the back end's adaptive threshold
      unique case (cfg_index_i)
        REG_VOICE:   cfg_q.voice   <= cfg_data_i;
        REG_VIDEO:   cfg_q.video   <= cfg_data_i;
        REG_DEFAULT: cfg_q.dflt    <= cfg_data_i;
        REG_B_FLOOR: cfg_q.b_floor <= cfg_data_i;
        REG_B_CEIL:  cfg_q.b_ceil  <= cfg_data_i;
        REG_B_STEP:  cfg_q.b_step  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aac_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .traffic_class_i (traffic_class_i),
    .packet_size_i   (packet_size_i),
    .flow_rate_i     (flow_rate_i),
    .push_o          (push),
    .item_o          (push_item),
    .full_i          (full)
  );

  aac_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (empty)
  );

  aac_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .bload_i            (bload),
    .empty_i            (empty),
    .item_i             (pop_item),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .admitted_o         (admitted_o),
    .required_airtime_o (required_airtime_o),
    .threshold_used_o   (threshold_used_o),
    .utilization_now_o  (utilization_now_o)
  );

endmodule

// ===== hdl/aac_div.sv =====
// Restoring divider for the airtime quotient, saturating at the quotient width.
module aac_div
  import aac_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [AIR_W-1:0] quot_o
);

  typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN} div_state_e;

  localparam int unsigned CNT_W = $clog2(AIR_W);

  div_state_e       state_q, state_d;
  logic [NUM_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] dsh_q, dsh_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [AIR_W-1:0] quot_q, quot_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    den_d   = den_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      D_IDLE: begin
        if (start_i) begin
          rem_d   = num_i;
          den_d   = den_i;
          state_d = D_CHECK;
        end
      end
      D_CHECK: begin
        // quotient would not fit: saturate (also covers a zero divisor)
        if (rem_q >= (NUM_W'(den_q) << AIR_W)) begin
          quot_d  = AIR_MAX;
          done_d  = 1'b1;
          state_d = D_IDLE;
        end else begin
          dsh_d   = NUM_W'(den_q) << (AIR_W - 1);
          quot_d  = '0;
          cnt_d   = '0;
          state_d = D_RUN;
        end
      end
      D_RUN: begin
        if (rem_q >= dsh_q) begin
          rem_d  = rem_q - dsh_q;
          quot_d = {quot_q[AIR_W-2:0], 1'b1};
        end else begin
          quot_d = {quot_q[AIR_W-2:0], 1'b0};
        end
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(AIR_W - 1)) begin
          done_d  = 1'b1;
          state_d = D_IDLE;
        end
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      rem_q   <= '0;
      dsh_q   <= '0;
      den_q   <= '0;
      quot_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      dsh_q   <= dsh_d;
      den_q   <= den_d;
      quot_q  <= quot_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== hdl/aac_front.sv =====
// Front end: accepts requests, works out the airtime and queues class and airtime.
module aac_front
  import aac_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CLS_W-1:0]  traffic_class_i,
  input  logic [SIZE_W-1:0] packet_size_i,
  input  logic [RATE_W-1:0] flow_rate_i,
  output logic              push_o,
  output aac_item_t         item_o,
  input  logic              full_i
);

  typedef enum logic [2:0] {F_IDLE, F_MUL1, F_MUL2, F_START, F_WAIT, F_PUSH} front_state_e;

  front_state_e      state_q, state_d;
  logic [CLS_W-1:0]  cls_q, cls_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [RATE_W-1:0] rate_q, rate_d;
  logic [TERM_W-1:0] term_q, term_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [AIR_W-1:0]  air_q, air_d;

  logic             div_done;
  logic [AIR_W-1:0] div_quot;

  aac_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == F_START),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d = state_q;
    cls_d   = cls_q;
    size_d  = size_q;
    rate_d  = rate_q;
    term_d  = term_q;
    prod_d  = prod_q;
    num_d   = num_q;
    den_d   = den_q;
    air_d   = air_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          cls_d   = traffic_class_i;
          size_d  = packet_size_i;
          rate_d  = flow_rate_i;
          term_d  = TERM_W'({packet_size_i, 3'b000}) + TERM_OFFSET;
          state_d = F_MUL1;
        end
      end
      F_MUL1: begin
        prod_d  = PROD_W'(rate_q) * PROD_W'(term_q);
        den_d   = DEN_W'(size_q) * DEN_W'(DEN_SCALE);
        state_d = F_MUL2;
      end
      F_MUL2: begin
        num_d   = NUM_W'(prod_q) * NUM_W'(AIR_GAIN);
        state_d = F_START;
      end
      F_START: state_d = F_WAIT;
      F_WAIT: begin
        if (div_done) begin
          air_d   = div_quot;
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cls_q   <= '0;
      size_q  <= '0;
      rate_q  <= '0;
      term_q  <= '0;
      prod_q  <= '0;
      num_q   <= '0;
      den_q   <= '0;
      air_q   <= '0;
    end else begin
      state_q <= state_d;
      cls_q   <= cls_d;
      size_q  <= size_d;
      rate_q  <= rate_d;
      term_q  <= term_d;
      prod_q  <= prod_d;
      num_q   <= num_d;
      den_q   <= den_d;
      air_q   <= air_d;
    end
  end

  assign in_ready_o = (state_q == F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !full_i;
  assign item_o.cls = cls_q;
  assign item_o.air = air_q;

endmodule

// ===== hdl/aac_queue.sv =====
// Small queue of classified words between the front and back ends.
module aac_queue
  import aac_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  aac_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output aac_item_t item_o,
  output logic      empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  aac_item_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  logic do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/aac_back.sv =====
// Back end: adapts the bursty threshold, decides admission and holds the result.
module aac_back
  import aac_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aac_cfg_t          cfg_i,
  input  aac_bload_t        bload_i,
  input  logic              empty_i,
  input  aac_item_t         item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              admitted_o,
  output logic [AIR_W-1:0]  required_airtime_o,
  output logic [THR_W-1:0]  threshold_used_o,
  output logic [THR_W-1:0]  utilization_now_o
);

  typedef enum logic [1:0] {B_IDLE, B_ADAPT, B_DECIDE} back_state_e;

  back_state_e      state_q, state_d;
  aac_item_t        item_q, item_d;
  logic [THR_W-1:0] util_q, util_d;
  logic [THR_W-1:0] bursty_q, bursty_d;
  logic             out_valid_q, out_valid_d;
  logic             adm_q, adm_d;
  logic [AIR_W-1:0] air_q, air_d;
  logic [THR_W-1:0] thr_q, thr_d;

  logic [THR_W:0]   lowered, raised;
  logic [THR_W-1:0] thr_sel;
  logic [AIR_W:0]   total;
  logic             fits;

  assign lowered = {1'b0, bursty_q} - {1'b0, cfg_i.b_step};
  assign raised  = {1'b0, bursty_q} + {1'b0, cfg_i.b_step};

  always_comb begin
    unique case (item_q.cls)
      CLS_VOICE:  thr_sel = cfg_i.voice;
      CLS_VIDEO:  thr_sel = cfg_i.video;
      CLS_BURSTY: thr_sel = bursty_q;
      CLS_OTHER:  thr_sel = cfg_i.dflt;
      default:    thr_sel = cfg_i.dflt;
    endcase
  end

  assign total = (AIR_W + 1)'(util_q) + {1'b0, item_q.air};
  assign fits  = (total <= (AIR_W + 1)'(thr_sel));

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    util_d      = util_q;
    bursty_d    = bursty_q;
    out_valid_d = out_valid_q;
    adm_d       = adm_q;
    air_d       = air_q;
    thr_d       = thr_q;
    pop_o       = 1'b0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          item_d  = item_i;
          state_d = B_ADAPT;
        end
      end
      B_ADAPT: begin
        if (util_q >= UTIL_LOWER_MIN) begin
          // a negative difference always loses to the floor
          bursty_d = (!lowered[THR_W] && (lowered[THR_W-1:0] > cfg_i.b_floor)) ?
                     lowered[THR_W-1:0] : cfg_i.b_floor;
        end else if ((util_q >= UTIL_RAISE_MIN) && (util_q <= UTIL_RAISE_MAX)) begin
          bursty_d = (raised < {1'b0, cfg_i.b_ceil}) ? raised[THR_W-1:0] : cfg_i.b_ceil;
        end
        state_d = B_DECIDE;
      end
      B_DECIDE: begin
        if (!out_valid_q || out_ready_i) begin
          adm_d       = fits;
          air_d       = item_q.air;
          thr_d       = thr_sel;
          if (fits) util_d = total[THR_W-1:0];
          out_valid_d = 1'b1;
          state_d     = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase

    if (bload_i.load) bursty_d = bload_i.value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      item_q      <= '0;
      util_q      <= '0;
      bursty_q    <= RST_B_START;
      out_valid_q <= 1'b0;
      adm_q       <= 1'b0;
      air_q       <= '0;
      thr_q       <= '0;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      util_q      <= util_d;
      bursty_q    <= bursty_d;
      out_valid_q <= out_valid_d;
      adm_q       <= adm_d;
      air_q       <= air_d;
      thr_q       <= thr_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign admitted_o         = adm_q;
  assign required_airtime_o = air_q;
  assign threshold_used_o   = thr_q;
  assign utilization_now_o  = util_q;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the airtime admission control block.
`timescale 1ns / 1ps

module tb;
  import aac_pkg::*;

  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned NUM_PHASES    = 10;
  localparam int unsigned PHASE_ITEMS   = 130;
  localparam int unsigned LONG_HOLD_AT  = 300;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned MAX_PRINTED   = 40;

  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;  // no register behind this index
  localparam logic [IDX_W-1:0] REG_ORDER [8] = '{REG_VOICE, REG_VIDEO, REG_B_START,
                                                 REG_DEFAULT, REG_B_FLOOR, REG_B_CEIL,
                                                 REG_B_STEP, REG_NONE};

  typedef struct packed {
    logic             admitted;
    logic [AIR_W-1:0] airtime;
    logic [THR_W-1:0] threshold;
    logic [THR_W-1:0] util;
  } decision_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [CLS_W-1:0]  cls;
    logic [SIZE_W-1:0] size;
    logic [RATE_W-1:0] rate;
    logic [IDX_W-1:0]  idx;
    logic [THR_W-1:0]  data;
    logic              known;
    decision_t         want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic [CLS_W-1:0]  req_cls = '0;
  logic [SIZE_W-1:0] req_size = '0;
  logic [RATE_W-1:0] req_rate = '0;
  logic              out_ready = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [THR_W-1:0]  cfg_data = '0;
  // typed-in result of the word on offer, if any
  logic              req_known = 1'b0;
  decision_t         req_want = '0;

  logic              in_ready;
  logic              out_valid;
  logic              admitted;
  logic [AIR_W-1:0]  required_airtime;
  logic [THR_W-1:0]  threshold_used;
  logic [THR_W-1:0]  utilization_now;
  logic              cfg_ready;

  // shadow of the block's registers and state
  logic [THR_W-1:0]  thr_voice   = RST_VOICE;
  logic [THR_W-1:0]  thr_video   = RST_VIDEO;
  logic [THR_W-1:0]  thr_default = RST_DEFAULT;
  logic [THR_W-1:0]  b_floor     = RST_B_FLOOR;
  logic [THR_W-1:0]  b_ceil      = RST_B_CEIL;
  logic [THR_W-1:0]  b_step      = RST_B_STEP;
  logic [THR_W-1:0]  bursty_thr  = RST_B_START;
  logic [THR_W-1:0]  util_held   = '0;

  decision_t   decision_q [$];
  plan_row_t   plan [$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_requests = 0;
  int unsigned n_admitted = 0;
  int unsigned n_writes = 0;
  int unsigned n_lowered = 0;
  int unsigned n_raised = 0;
  int unsigned n_settings = 0;
  bit          src_burst = 1'b0;
  bit          sink_burst = 1'b0;

  airtime_admission_control dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .traffic_class_i    (req_cls),
    .packet_size_i      (req_size),
    .flow_rate_i        (req_rate),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .admitted_o         (admitted),
    .required_airtime_o (required_airtime),
    .threshold_used_o   (threshold_used),
    .utilization_now_o  (utilization_now),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want_v);
    if (mismatches < MAX_PRINTED)
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want_v, $realtime);
    mismatches++;
  endtask

  // Adapts the bursty limit, works out the airtime share and decides one request.
  function automatic decision_t decide(input logic [CLS_W-1:0] c, input logic [SIZE_W-1:0] s,
                                       input logic [RATE_W-1:0] r);
    decision_t          d;
    logic [63:0]        u, num, den, q;
    logic signed [63:0] v;
    logic [AIR_W-1:0]   air;
    logic [THR_W-1:0]   thr;
    logic [AIR_W:0]     sum;
    u = {48'd0, util_held};
    if (u * 20 > 64'd19 * 65536) begin
      v = $signed({48'd0, bursty_thr}) - $signed({48'd0, b_step});
      bursty_thr = (v > $signed({48'd0, b_floor})) ? v[THR_W-1:0] : b_floor;
      n_lowered++;
    end else if (u * 10 > 64'd7 * 65536 && u * 10 <= 64'd9 * 65536) begin
      v = $signed({48'd0, bursty_thr}) + $signed({48'd0, b_step});
      bursty_thr = (v < $signed({48'd0, b_ceil})) ? v[THR_W-1:0] : b_ceil;
      n_raised++;
    end
    if (s == '0) begin
      air = AIR_MAX;
    end else begin
      num = {34'd0, r} * ({48'd0, s} * 8 + 64'd10000) * 64'd176;
      den = {48'd0, s} * 64'd1953125;
      q   = num / den;
      air = (q > {44'd0, AIR_MAX}) ? AIR_MAX : q[AIR_W-1:0];
    end
    case (c)
      CLS_VOICE:  thr = thr_voice;
      CLS_VIDEO:  thr = thr_video;
      CLS_BURSTY: thr = bursty_thr;
      default:    thr = thr_default;
    endcase
    sum = {5'd0, util_held} + {1'b0, air};
    d.admitted = (sum <= {5'd0, thr});
    if (d.admitted) util_held = sum[THR_W-1:0];
    d.airtime   = air;
    d.threshold = thr;
    d.util      = util_held;
    return d;
  endfunction

  function automatic plan_row_t row_req(input logic [CLS_W-1:0] c, input logic [SIZE_W-1:0] s,
                                        input logic [RATE_W-1:0] r);
    plan_row_t p;
    p      = '0;
    p.kind = ROW_REQ;
    p.cls  = c;
    p.size = s;
    p.rate = r;
    return p;
  endfunction

  function automatic plan_row_t row_known(input logic [CLS_W-1:0] c, input logic [SIZE_W-1:0] s,
                                          input logic [RATE_W-1:0] r, input logic adm,
                                          input logic [AIR_W-1:0] air,
                                          input logic [THR_W-1:0] thr,
                                          input logic [THR_W-1:0] util);
    plan_row_t p;
    p       = row_req(c, s, r);
    p.known = 1'b1;
    p.want  = '{admitted: adm, airtime: air, threshold: thr, util: util};
    return p;
  endfunction

  function automatic plan_row_t row_write(input logic [IDX_W-1:0] idx,
                                          input logic [THR_W-1:0] data);
    plan_row_t p;
    p      = '0;
    p.kind = ROW_CFG;
    p.idx  = idx;
    p.data = data;
    return p;
  endfunction

  // Offers one request word after a random gap (none in burst mode); returns at the edge that takes it.
  task automatic offer(input logic [CLS_W-1:0] c, input logic [SIZE_W-1:0] s,
                       input logic [RATE_W-1:0] r, input logic known, input decision_t want);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_cls   <= c;
    req_size  <= s;
    req_rate  <= r;
    req_known <= known;
    req_want  <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // Caller lowers cfg_valid once the batch of writes is done.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [THR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Stop offering and let every outstanding result come back.
  // It first lets the current edge pass, so a word taken there is already on the scoreboard.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decision_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : scoreboard
    decision_t want;
    logic      busy;
    if (rst_n) begin
      busy = 1'b0;
      if (cfg_valid && cfg_ready) begin
        busy = 1'b1;
        n_writes++;
        case (cfg_index)
          REG_VOICE:   thr_voice = cfg_data;
          REG_VIDEO:   thr_video = cfg_data;
          REG_B_START: bursty_thr = cfg_data;
          REG_DEFAULT: thr_default = cfg_data;
          REG_B_FLOOR: b_floor = cfg_data;
          REG_B_CEIL:  b_ceil = cfg_data;
          REG_B_STEP:  b_step = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        busy = 1'b1;
        want = decide(req_cls, req_size, req_rate);
        if (req_known) want = req_want;
        if (want.admitted) n_admitted++;
        n_requests++;
        decision_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        busy = 1'b1;
        if (decision_q.size() == 0) begin
          report_mismatch("result word with nothing outstanding, airtime", required_airtime, 0);
        end else begin
          want = decision_q.pop_front();
          if (admitted !== want.admitted)
            report_mismatch("admitted", admitted, want.admitted);
          if (required_airtime !== want.airtime)
            report_mismatch("required_airtime", required_airtime, want.airtime);
          if (threshold_used !== want.threshold)
            report_mismatch("threshold_used", threshold_used, want.threshold);
          if (utilization_now !== want.util)
            report_mismatch("utilization_now", utilization_now, want.util);
        end
      end
      idle_cycles <= busy ? 0 : idle_cycles + 1;
    end
  end

  initial begin : result_sink
    int unsigned taken;
    int unsigned gap;
    taken = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        taken++;
        // one long hold-off so the block backs up and stalls its input
        if (taken == LONG_HOLD_AT) gap = LONG_HOLD;
        else gap = sink_burst ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    wait (rst_n === 1'b1);
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    bit                in_cfg;
    int unsigned       k;
    int unsigned       n;
    int unsigned       pick;
    logic [THR_W-1:0]  v;
    logic [CLS_W-1:0]  c;
    logic [SIZE_W-1:0] s;
    logic [RATE_W-1:0] r;
    in_cfg = 1'b0;

    // fresh out of reset, then climb into the raise band, then past 0.95
    plan.push_back(row_known(CLS_VOICE, '0, '0, 1'b0, AIR_MAX, RST_VOICE, '0));
    plan.push_back(row_known(CLS_VIDEO, 16'd1500, '0, 1'b1, '0, RST_VIDEO, '0));
    plan.push_back(row_known(CLS_OTHER, 16'd1, 30'd1_000_000_000, 1'b0, AIR_MAX,
                             RST_DEFAULT, '0));
    plan.push_back(row_req(CLS_BURSTY, '1, '1));
    plan.push_back(row_known(CLS_BURSTY, 16'd1, '0, 1'b1, '0, RST_B_START, '0));
    plan.push_back(row_known(CLS_VOICE, '1, '0, 1'b1, '0, RST_VOICE, '0));
    plan.push_back(row_write(REG_NONE, '0));
    plan.push_back(row_write(REG_DEFAULT, '1));
    plan.push_back(row_req(CLS_OTHER, '1, 30'd68_000_000));
    plan.push_back(row_req(CLS_BURSTY, 16'd1500, '0));
    plan.push_back(row_write(REG_B_CEIL, '0));
    plan.push_back(row_req(CLS_BURSTY, 16'd1500, '0));     // ceiling drags it down
    plan.push_back(row_write(REG_B_CEIL, '1));
    plan.push_back(row_write(REG_B_STEP, '1));
    plan.push_back(row_req(CLS_BURSTY, 16'd512, '0));
    plan.push_back(row_write(REG_B_STEP, '0));
    plan.push_back(row_write(REG_B_START, 16'd1000));      // reloads the live limit
    plan.push_back(row_req(CLS_BURSTY, 16'd512, '0));
    plan.push_back(row_req(CLS_OTHER, '1, 30'd16_900_000));
    plan.push_back(row_write(REG_B_STEP, RST_B_STEP));
    plan.push_back(row_req(CLS_BURSTY, 16'd1500, '0));     // floor lifts it
    plan.push_back(row_write(REG_B_STEP, '1));
    plan.push_back(row_req(CLS_BURSTY, 16'd1500, '0));     // step larger than the limit
    plan.push_back(row_write(REG_B_FLOOR, '0));
    plan.push_back(row_req(CLS_BURSTY, 16'd1500, '0));
    plan.push_back(row_write(REG_VOICE, '0));
    plan.push_back(row_write(REG_VIDEO, '1));
    plan.push_back(row_req(CLS_VOICE, 16'd1500, '0));
    plan.push_back(row_req(CLS_VIDEO, 16'd1, '0));
    plan.push_back(row_req(CLS_VIDEO, 16'd255, 30'd1_000_000));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (!in_cfg) begin
          drain();
          in_cfg = 1'b1;
        end
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        if (in_cfg) begin
          cfg_valid <= 1'b0;
          in_cfg = 1'b0;
        end
        offer(plan[i].cls, plan[i].size, plan[i].rate, plan[i].known, plan[i].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      n_settings++;
      src_burst  = ($urandom_range(0, 3) == 0);
      sink_burst = ($urandom_range(0, 3) == 0);
      for (k = 0; k < 8; k++) begin
        if (ph == 0) begin
          v = '1;
        end else if (ph == 1) begin
          v = '0;
        end else if (REG_ORDER[k] == REG_B_STEP) begin
          v = ($urandom_range(0, 9) < 7) ? THR_W'($urandom_range(0, 2000))
                                         : THR_W'($urandom_range(0, 65535));
        end else if (REG_ORDER[k] == REG_B_FLOOR || REG_ORDER[k] == REG_B_CEIL) begin
          v = THR_W'($urandom_range(0, 65535));
        end else begin
          // limits mostly near the top, since utilisation only ever grows
          pick = $urandom_range(0, 9);
          if (pick < 5) v = '1;
          else if (pick < 8) v = THR_W'($urandom_range(60000, 65535));
          else v = THR_W'($urandom_range(0, 65535));
        end
        if (ph < 2 || $urandom_range(0, 1) == 1) write_reg(REG_ORDER[k], v);
      end
      cfg_valid <= 1'b0;

      for (n = 0; n < PHASE_ITEMS; n++) begin
        c    = CLS_W'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick == 0) s = '0;
        else if (pick < 20) s = SIZE_W'($urandom_range(1, 255));
        else s = SIZE_W'($urandom_range(1, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 60) r = RATE_W'($urandom_range(0, 2000));
        else if (pick < 85) r = RATE_W'($urandom_range(0, 100000));
        else r = RATE_W'($urandom_range(0, 1_000_000_000));
        offer(c, s, r, 1'b0, '0);
      end
    end

    drain();
    if (decision_q.size() != 0)
      report_mismatch("results never delivered", decision_q.size(), 0);
    $display("Covered %0d requests (%0d admitted, %0d blocked) over %0d settings, %0d writes",
             n_requests, n_admitted, n_requests - n_admitted, n_settings + 1, n_writes);
    $display("Bursty limit lowered %0d times and raised %0d times; %0d mismatches",
             n_lowered, n_raised, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/aac_pkg.sv
hdl/aac_div.sv
hdl/aac_front.sv
hdl/aac_queue.sv
hdl/aac_back.sv
hdl/airtime_admission_control.sv
verif/tb.sv
